// ===== hdl/rsk_pkg.sv =====
// Shared types, constants and tables for the rover wheel kinematics block.
// No dependencies; every other file imports this package.
package rsk_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMaxSpeed    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegMaxSteer    = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegTrackWidth  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegAxleBase    = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegTireDiam    = CfgIdxW'(4);

  localparam logic [11:0] MaxSpeedRst   = 12'd1000;
  localparam logic [14:0] MaxSteerRst   = 15'd8192;
  localparam logic [11:0] TrackWidthRst = 12'd400;
  localparam logic [11:0] AxleBaseRst   = 12'd1551;
  localparam logic [10:0] TireDiamRst   = 11'd300;

  localparam logic [14:0] ThetaMax   = 15'd25735;
  localparam logic [20:0] RateMax    = 21'd1048575;
  localparam int unsigned StickFull  = 32767;
  localparam int unsigned StickHalf  = 16383;
  localparam int unsigned R0Scale    = 512000;
  localparam int unsigned CordicGain = 39797;
  localparam int unsigned CordicSteps = 16;

  localparam int unsigned DivNumW  = 48;
  localparam int unsigned DivDenW  = 32;
  localparam int unsigned CordicW  = 34;
  localparam int unsigned CordicZW = 20;

  typedef struct packed {
    logic [27:0] fwd_prod;    // |forward| * max_speed
    logic [30:0] steer_prod;  // |turn| * max_steer
    logic        neg;         // stick_forward above zero
    logic        turn_neg;    // left turn
    logic        turn_pos;    // right turn
  } rsk_item_t;

  typedef struct packed {
    logic [10:0] tire;
    logic [11:0] base;
    logic [11:0] track;
  } rsk_geom_t;

  // CORDIC step angles in 2^-16 rad
  function automatic logic [16:0] rsk_step_angle(input logic [3:0] idx);
    logic [16:0] a;
    case (idx)
      4'd0:    a = 17'd51472;
      4'd1:    a = 17'd30386;
      4'd2:    a = 17'd16055;
      4'd3:    a = 17'd8150;
      4'd4:    a = 17'd4091;
      4'd5:    a = 17'd2047;
      4'd6:    a = 17'd1024;
      4'd7:    a = 17'd512;
      4'd8:    a = 17'd256;
      4'd9:    a = 17'd128;
      4'd10:   a = 17'd64;
      4'd11:   a = 17'd32;
      4'd12:   a = 17'd16;
      4'd13:   a = 17'd8;
      4'd14:   a = 17'd4;
      default: a = 17'd2;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/rsk_if.sv =====
// Channel interfaces: stick requests in, wheel results out, register writes.
// Depends on rsk_pkg.
interface rsk_in_if import rsk_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [15:0] stick_forward;
  logic signed [15:0] stick_turn;
  modport source (output valid, stick_forward, stick_turn, input ready);
  modport sink   (input valid, stick_forward, stick_turn, output ready);
endinterface

interface rsk_out_if import rsk_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [20:0] rate_right_front;
  logic signed [20:0] rate_left_front;
  logic signed [20:0] rate_right_middle;
  logic signed [20:0] rate_left_middle;
  logic signed [20:0] rate_right_rear;
  logic signed [20:0] rate_left_rear;
  logic signed [15:0] angle_right_front;
  logic signed [15:0] angle_left_front;
  logic signed [15:0] angle_right_rear;
  logic signed [15:0] angle_left_rear;
  modport source (output valid, rate_right_front, rate_left_front, rate_right_middle,
                  rate_left_middle, rate_right_rear, rate_left_rear, angle_right_front,
                  angle_left_front, angle_right_rear, angle_left_rear, input ready);
  modport sink   (input valid, rate_right_front, rate_left_front, rate_right_middle,
                  rate_left_middle, rate_right_rear, rate_left_rear, angle_right_front,
                  angle_left_front, angle_right_rear, angle_left_rear, output ready);
endinterface

interface rsk_cfg_if import rsk_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/rsk_front.sv =====
// Front end: accepts stick requests, takes magnitudes and signs, forms products.
// Depends on rsk_pkg and rsk_in_if.
module rsk_front import rsk_pkg::*; (
  rsk_in_if.sink      in_i,
  input  logic [11:0] max_speed_i,
  input  logic [14:0] max_steer_i,
  input  logic        full_i,
  output logic        push_o,
  output rsk_item_t   item_o
);

  logic [15:0] fa;
  logic [15:0] ta;

  // magnitude; the most negative code maps to 32768
  assign fa = in_i.stick_forward[15] ? (~in_i.stick_forward + 16'd1) : in_i.stick_forward;
  assign ta = in_i.stick_turn[15] ? (~in_i.stick_turn + 16'd1) : in_i.stick_turn;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    item_o.fwd_prod   = 28'(fa) * 28'(max_speed_i);
    item_o.steer_prod = 31'(ta) * 31'(max_steer_i);
    item_o.neg        = !in_i.stick_forward[15] && (in_i.stick_forward != '0);
    item_o.turn_neg   = in_i.stick_turn[15];
    item_o.turn_pos   = !in_i.stick_turn[15] && (in_i.stick_turn != '0);
  end

endmodule

// ===== hdl/rsk_queue.sv =====
// Short request queue between front end and back end.
// Depends on rsk_pkg.
module rsk_queue import rsk_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  rsk_item_t item_i,
  input  logic      pop_i,
  output rsk_item_t item_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rsk_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != CntW'(Depth))) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0)) else $error("queue pop while empty");

endmodule

// ===== hdl/rsk_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on rsk_pkg.
module rsk_div import rsk_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output logic               done_o,
  output logic [DivNumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(DivNumW);

  logic               busy_q, done_q;
  logic [CntW-1:0]    cnt_q;
  logic [DivNumW-1:0] acc_q;
  logic [DivDenW:0]   rem_q;
  logic [DivDenW-1:0] den_q;
  logic [DivDenW:0]   rem_sh, rem_nx;
  logic               ge;

  always_comb begin
    rem_sh = {rem_q[DivDenW-1:0], acc_q[DivNumW-1]};
    ge     = (rem_sh >= {1'b0, den_q});
    rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  assign done_o = done_q;
  assign quo_o  = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(DivNumW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[DivNumW-2:0], ge};
      rem_q <= rem_nx;
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");

endmodule

// ===== hdl/rsk_cordic.sv =====
// Iterative CORDIC, rotation or vectoring mode, one step per cycle.
// Depends on rsk_pkg (step angle table).
module rsk_cordic import rsk_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       vec_i,
  input  logic signed [CordicW-1:0]  x_i,
  input  logic signed [CordicW-1:0]  y_i,
  input  logic signed [CordicZW-1:0] z_i,
  output logic                       done_o,
  output logic signed [CordicW-1:0]  x_o,
  output logic signed [CordicW-1:0]  y_o,
  output logic signed [CordicZW-1:0] z_o
);

  localparam int unsigned ItW = $clog2(CordicSteps);

  logic                       busy_q, done_q, vec_q;
  logic [ItW-1:0]             it_q;
  logic signed [CordicW-1:0]  x_q, y_q, dx, dy;
  logic signed [CordicZW-1:0] z_q, ang;
  logic                       sigma;

  always_comb begin
    dx    = y_q >>> it_q;
    dy    = x_q >>> it_q;
    ang   = $signed({{(CordicZW - 17){1'b0}}, rsk_step_angle(4'(it_q))});
    // rotate toward zero residual angle, or toward the x axis
    sigma = vec_q ? (y_q[CordicW-1] || (y_q == '0)) : !z_q[CordicZW-1];
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      it_q   <= '0;
    end else if (busy_q) begin
      it_q <= it_q + ItW'(1);
      if (it_q == ItW'(CordicSteps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      vec_q <= vec_i;
      x_q   <= x_i;
      y_q   <= y_i;
      z_q   <= z_i;
    end else if (busy_q) begin
      if (sigma) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - ang;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + ang;
      end
    end
  end

endmodule

// ===== hdl/rsk_back.sv =====
// Back end: sequencer over the shared divider and CORDIC, square root, rate
// products and the result register. Depends on rsk_pkg, rsk_div, rsk_cordic.
module rsk_back import rsk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rsk_geom_t geom_i,
  input  logic      empty_i,
  input  rsk_item_t item_i,
  output logic      pop_o,
  rsk_out_if.source out_o
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_THETA = 12'b000000000010,
    S_R0    = 12'b000000000100,
    S_ROT   = 12'b000000001000,
    S_GEOM  = 12'b000000010000,
    S_VEC   = 12'b000000100000,
    S_SQX   = 12'b000001000000,
    S_SQY   = 12'b000010000000,
    S_SQRT  = 12'b000100000000,
    S_DIV   = 12'b001000000000,
    S_RATE  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } rsk_state_e;

  localparam logic [1:0] RatInF  = 2'd0;
  localparam logic [1:0] RatInM  = 2'd1;
  localparam logic [1:0] RatOutM = 2'd2;
  localparam logic [1:0] RatOutF = 2'd3;

  rsk_state_e state_q, state_d;
  logic       launch_q, launch_d;
  logic [1:0] sel_q, sel_d;
  logic       out_valid_q, out_take;

  rsk_item_t          item_q;
  logic [14:0]        theta_q, phi_q;
  logic [31:0]        r0_q;
  logic [16:0]        c_q, s_q;
  logic [28:0]        bc_q, y_q;
  logic [29:0]        q_q;
  logic [30:0]        x_q;
  logic [63:0]        sum_q, res_q, bit_q;
  logic [31:0]        ratio_q [4];
  logic signed [20:0] rate_q [4];

  logic               div_start, div_done;
  logic [DivNumW-1:0] div_num, div_quo, div_base;
  logic [DivDenW-1:0] div_den, den_r0;
  logic               cor_start, cor_done, cor_vec;
  logic signed [CordicW-1:0]  cor_x_in, cor_y_in, cor_x, cor_y;
  logic signed [CordicZW-1:0] cor_z_in, cor_z;
  logic [19:0]        z_rnd;
  logic [28:0]        bc, ss;
  logic [63:0]        trial, prod;
  logic [39:0]        mag;
  logic [20:0]        mag_sat;
  logic               left, inner, neg_w;
  logic [1:0]         rat_idx;
  logic signed [15:0] th_s, ph_s, ang_r, ang_l;
  logic [29:0]        th_num;
  logic [60:0]        th_prod;
  logic [15:0]        th_quo;

  function automatic logic [31:0] lim32(input logic [DivNumW-1:0] v);
    return (v[DivNumW-1:32] != '0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // ---------------- shared units ----------------
  always_comb begin
    den_r0 = DivDenW'({geom_i.tire, 15'b0}) - DivDenW'(geom_i.tire);
    case (sel_q)
      RatInF:  div_base = DivNumW'({geom_i.base, 32'b0});
      RatInM:  div_base = DivNumW'({bc_q, 16'b0});
      RatOutM: div_base = DivNumW'({x_q, 16'b0});
      default: div_base = DivNumW'({res_q[31:0], 16'b0});
    endcase
    div_start = !launch_q && (state_q == S_R0 || state_q == S_DIV);
    case (state_q)
      S_R0: begin
        div_num = DivNumW'(item_q.fwd_prod) * DivNumW'(R0Scale) + DivNumW'(den_r0 >> 1);
        div_den = den_r0;
      end
      S_DIV: begin
        div_num = div_base + DivNumW'(q_q >> 1);
        div_den = DivDenW'(q_q);
      end
      default: begin
        div_num = '0;
        div_den = '1;
      end
    endcase
  end

  rsk_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    cor_start = !launch_q && (state_q == S_ROT || state_q == S_VEC);
    cor_vec   = (state_q == S_VEC);
    cor_x_in  = cor_vec ? $signed(CordicW'(x_q)) : $signed(CordicW'(CordicGain));
    cor_y_in  = cor_vec ? $signed(CordicW'(y_q)) : '0;
    cor_z_in  = cor_vec ? '0 : $signed(CordicZW'({theta_q, 2'b00}));
  end

  rsk_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .vec_i   (cor_vec),
    .x_i     (cor_x_in),
    .y_i     (cor_y_in),
    .z_i     (cor_z_in),
    .done_o  (cor_done),
    .x_o     (cor_x),
    .y_o     (cor_y),
    .z_o     (cor_z)
  );

  // ---------------- sequencer ----------------
  assign out_take = !out_valid_q || out_o.ready;

  always_comb begin
    state_d  = state_q;
    launch_d = launch_q;
    sel_d    = sel_q;
    pop_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o    = 1'b1;
          launch_d = 1'b0;
          state_d  = S_THETA;
        end
      end
      S_THETA: state_d = S_R0;
      S_R0: begin
        if (!launch_q) begin
          launch_d = 1'b1;
        end else if (div_done) begin
          launch_d = 1'b0;
          sel_d    = '0;
          if ((item_q.turn_neg || item_q.turn_pos) && (theta_q != '0)) begin
            state_d = S_ROT;
          end else begin
            state_d = S_RATE;
          end
        end
      end
      S_ROT: begin
        if (!launch_q) begin
          launch_d = 1'b1;
        end else if (cor_done) begin
          launch_d = 1'b0;
          state_d  = S_GEOM;
        end
      end
      S_GEOM: state_d = S_VEC;
      S_VEC: begin
        if (!launch_q) begin
          launch_d = 1'b1;
        end else if (cor_done) begin
          launch_d = 1'b0;
          state_d  = S_SQX;
        end
      end
      S_SQX: state_d = S_SQY;
      S_SQY: state_d = S_SQRT;
      S_SQRT: begin
        if (bit_q == '0) begin
          sel_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!launch_q) begin
          launch_d = 1'b1;
        end else if (div_done) begin
          launch_d = 1'b0;
          sel_d    = sel_q + 2'd1;
          if (sel_q == 2'd3) state_d = S_RATE;
        end
      end
      S_RATE: begin
        sel_d = sel_q + 2'd1;
        if (sel_q == 2'd3) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_take) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= 1'b0;
      sel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      sel_q    <= sel_d;
      if (state_q == S_OUT && out_take) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- datapath ----------------
  always_comb begin
    // divide by 32767: multiply by 2^30 + 2^15 + 2 and keep bits from 2^45 up,
    // exact for every numerator below 2^30
    th_num  = 30'(item_q.steer_prod) + 30'(StickHalf);
    th_prod = 61'({th_num, 30'b0}) + 61'({th_num, 15'b0}) + 61'({th_num, 1'b0});
    th_quo  = th_prod[60:45];
    bc    = 29'(geom_i.base) * 29'(c_q);
    ss    = 29'(geom_i.track) * 29'(s_q);
    z_rnd = 20'(cor_z) + 20'd2;
    trial = res_q + bit_q;
    // right side is inner unless turning left
    left    = sel_q[0];
    inner   = (left == item_q.turn_neg);
    rat_idx = inner ? (sel_q[1] ? RatInM : RatInF) : (sel_q[1] ? RatOutM : RatOutF);
    neg_w   = item_q.neg ^ left;
    prod    = 64'(r0_q) * 64'(ratio_q[rat_idx]) + 64'(1 << 23);
    mag     = prod[63:24];
    mag_sat = (mag > 40'(RateMax)) ? RateMax : mag[20:0];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (!empty_i) item_q <= item_i;
      end
      S_THETA: theta_q <= (th_quo > 16'(ThetaMax)) ? ThetaMax : th_quo[14:0];
      S_R0: begin
        if (launch_q && div_done) begin
          r0_q  <= lim32(div_quo);
          phi_q <= '0;
          for (int k = 0; k < 4; k++) ratio_q[k] <= 32'd65536;
        end
      end
      S_ROT: begin
        if (launch_q && cor_done) begin
          c_q <= cor_x[CordicW-1] ? 17'd0 : cor_x[16:0];
          s_q <= (cor_y[CordicW-1] || cor_y == '0) ? 17'd1 : cor_y[16:0];
        end
      end
      S_GEOM: begin
        bc_q <= bc;
        q_q  <= 30'(bc) + 30'(ss);
        x_q  <= 31'(bc) + 31'({ss, 1'b0});
        y_q  <= 29'(geom_i.base) * 29'(s_q);
      end
      S_VEC: begin
        if (launch_q && cor_done) begin
          phi_q <= cor_z[CordicZW-1] ? 15'd0 : z_rnd[16:2];
        end
      end
      S_SQX: sum_q <= 64'(x_q) * 64'(x_q);
      S_SQY: begin
        sum_q <= sum_q + 64'(y_q) * 64'(y_q);
        res_q <= '0;
        bit_q <= 64'(1) << 62;
      end
      S_SQRT: begin
        if (bit_q != '0) begin
          if (sum_q >= trial) begin
            sum_q <= sum_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
      end
      S_DIV: begin
        if (launch_q && div_done) ratio_q[sel_q] <= lim32(div_quo);
      end
      S_RATE: rate_q[sel_q] <= neg_w ? -$signed(mag_sat) : $signed(mag_sat);
      default: ;
    endcase
  end

  // ---------------- result register ----------------
  always_comb begin
    th_s = $signed({1'b0, theta_q});
    ph_s = $signed({1'b0, phi_q});
    if (item_q.turn_pos) begin
      ang_r = th_s;
      ang_l = ph_s;
    end else if (item_q.turn_neg) begin
      ang_r = -ph_s;
      ang_l = -th_s;
    end else begin
      ang_r = '0;
      ang_l = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_take) begin
      out_o.rate_right_front  <= rate_q[0];
      out_o.rate_left_front   <= rate_q[1];
      out_o.rate_right_middle <= rate_q[2];
      out_o.rate_left_middle  <= rate_q[3];
      out_o.rate_right_rear   <= rate_q[0];
      out_o.rate_left_rear    <= rate_q[1];
      out_o.angle_right_front <= ang_r;
      out_o.angle_left_front  <= ang_l;
      out_o.angle_right_rear  <= -ang_r;
      out_o.angle_left_rear   <= -ang_l;
    end
  end

  assign out_o.valid = out_valid_q;

  a_rot_needs_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROT) |-> (theta_q != '0) && (item_q.turn_neg || item_q.turn_pos))
    else $error("CORDIC rotation entered for a straight request");
  a_out_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && !out_valid_q |=> out_valid_q)
    else $error("finished result not presented");

endmodule

// ===== hdl/rover_steering_wheel_kinematics.sv =====
// Top level: configuration registers, front end, request queue and back end.
// Depends on rsk_pkg, rsk_if, rsk_front, rsk_queue, rsk_back.
//
//  port    dir  kind        contents
//  in_i    in   valid/ready stick_forward, stick_turn
//  out_o   out  valid/ready six wheel rates, four bogie angles
//  cfg_i   in   valid/ready register index, write data (always ready)
//
// The back end works on one request at a time and pops the next only after handing
// off its result. A straight request takes one division on the shared
// one-bit-per-cycle divider; a turning request takes five, plus two CORDIC passes
// (rotation, then vectoring) and a square root.
// Reset clears control state and loads the register defaults; no clearing pass.
// A held result keeps the back end in its hand-off state; input stalls once the
// queue is full.
module rover_steering_wheel_kinematics import rsk_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rsk_in_if.sink    in_i,
  rsk_out_if.source out_o,
  rsk_cfg_if.sink   cfg_i
);

  logic [11:0] max_speed_q, track_q, base_q;
  logic [14:0] max_steer_q;
  logic [10:0] tire_q;
  rsk_geom_t   geom;
  rsk_item_t   push_item, head_item;
  logic        push, pop, full, empty;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= MaxSpeedRst;
      max_steer_q <= MaxSteerRst;
      track_q     <= TrackWidthRst;
      base_q      <= AxleBaseRst;
      tire_q      <= TireDiamRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegMaxSpeed:   max_speed_q <= cfg_i.data[11:0];
        RegMaxSteer:   max_steer_q <= cfg_i.data[14:0];
        RegTrackWidth: track_q     <= cfg_i.data[11:0];
        RegAxleBase:   base_q      <= cfg_i.data[11:0];
        RegTireDiam:   tire_q      <= cfg_i.data[10:0];
        default: ;
      endcase
    end
  end

  // zero geometry reads as one
  always_comb begin
    geom.tire  = (tire_q == '0) ? 11'd1 : tire_q;
    geom.base  = (base_q == '0) ? 12'd1 : base_q;
    geom.track = (track_q == '0) ? 12'd1 : track_q;
  end

  rsk_front u_front (
    .in_i        (in_i),
    .max_speed_i (max_speed_q),
    .max_steer_i (max_steer_q),
    .full_i      (full),
    .push_o      (push),
    .item_o      (push_item)
  );

  rsk_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .full_o  (full),
    .empty_o (empty)
  );

  rsk_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .geom_i  (geom),
    .empty_i (empty),
    .item_i  (head_item),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
